@@ rtl/core/pal_pkg.sv @@
package pal_pkg;

	typedef enum logic [2:0] {
		ACT_INSERT    = 3'd0,
		ACT_ERASE     = 3'd1,
		ACT_POP       = 3'd2,
		ACT_OVERWRITE = 3'd3,
		ACT_READ      = 3'd4,
		ACT_CLEAR     = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_BADPOS = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	// per-cell update select
	typedef enum logic [1:0] {
		CELL_HOLD       = 2'd0,
		CELL_LOAD       = 2'd1,
		CELL_TAKE_LEFT  = 2'd2,
		CELL_TAKE_RIGHT = 2'd3
	} cell_op_t;

endpackage

@@ rtl/core/pal_cell.sv @@
module pal_cell import pal_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  cell_op_t             op,
	input  logic [WORD_BITS-1:0] load_word,
	input  logic [WORD_BITS-1:0] left_word,
	input  logic [WORD_BITS-1:0] right_word,
	output logic [WORD_BITS-1:0] word
);

	logic [WORD_BITS-1:0] word_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_LOAD:       word_q <= load_word;
			CELL_TAKE_LEFT:  word_q <= left_word;
			CELL_TAKE_RIGHT: word_q <= right_word;
			default:         word_q <= word_q;
		endcase
	end

	assign word = word_q;

endmodule

@@ rtl/core/positional_array_list_core.sv @@
// Bounded ordered list of data words built as a row of DEPTH word cells.
// Entries 0 .. entry_count-1 are valid. Each input transfer carries one action:
// insert (shifts later entries up, position clamped to the end, refused with
// a full status when the list holds min(capacity_limit, DEPTH) entries),
// erase (shifts later entries down), pop of the last entry, overwrite, read
// and clear. Every input transfer yields exactly one output transfer with the
// popped or read word (zero otherwise), the count after the action, an empty
// flag and a status. Throughput is one item per clock while out_ready is high:
// every cell compares its own index with the position and shifts or loads in
// the same cycle, so the next item sees the updated list right away. There is
// a single result register: a new item is taken in the same cycle the held
// result is taken, and while a result waits with out_ready low, in_ready stays
// low. capacity_limit must be written through cfg_we / cfg_data only while the
// block is idle; the block does not enforce this. Lowering it below the count
// drops the entries above it. Stored words reset to nothing defined; the count
// resets to zero and capacity_limit to 16.
module positional_array_list_core import pal_pkg::*; #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [3:0]  position,
	input  logic [31:0] value_in,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] value_out,
	output logic [4:0]  entry_count,
	output logic        is_empty,
	output logic [1:0]  status,
	// capacity register
	input  logic        cfg_we,
	input  logic [4:0]  cfg_data
);

	localparam int CW   = $clog2(DEPTH + 1);    // count width
	localparam int CMPW = (CW > 5) ? CW : 5;    // compare width
	localparam int AW   = $clog2(DEPTH);        // cell index width
	localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

	// state
	logic [CW-1:0]        count_q;
	logic [4:0]           cap_q;

	// result register
	logic                 out_valid_q;
	logic [31:0]          value_out_q;
	logic [4:0]           entry_count_q;
	logic                 is_empty_q;
	status_t              status_q;

	// cell row
	cell_op_t             cell_op [DEPTH];
	logic [WORD_BITS-1:0] cell_word [DEPTH];
	logic [WORD_BITS-1:0] left_w [DEPTH];
	logic [WORD_BITS-1:0] right_w [DEPTH];
	logic [WORD_BITS-1:0] load_w;

	logic                 accept;
	logic [CMPW-1:0]      count_x, cnt_m1, pos_x, pos_eff, ucap, cfg_ucap;
	logic                 full, has_any, pos_in;
	logic [CMPW-1:0]      count_nx;
	status_t              status_nx;
	logic                 rd_en;
	logic [CMPW-1:0]      rd_sel;
	logic [AW-1:0]        rd_idx;
	logic [31:0]          value_nx;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign load_w   = WORD_BITS'(value_in);

	// shared compares, done once and broadcast along the row
	always_comb begin
		count_x = CMPW'(count_q);
		cnt_m1  = count_x - CMPW'(1);
		pos_x   = CMPW'(position);
		ucap    = (CMPW'(cap_q) > DEPTH_C) ? DEPTH_C : CMPW'(cap_q);
		full    = count_x >= ucap;
		has_any = count_x != '0;
		pos_in  = pos_x < count_x;
		pos_eff = (pos_x > count_x) ? count_x : pos_x;
	end

	// next count, status and read select
	always_comb begin
		count_nx  = count_x;
		status_nx = ST_OK;
		rd_en     = 1'b0;
		rd_sel    = pos_x;
		case (action)
			ACT_INSERT: begin
				if (full) status_nx = ST_FULL;
				else      count_nx  = count_x + CMPW'(1);
			end
			ACT_ERASE: begin
				if (!has_any)     status_nx = ST_EMPTY;
				else if (!pos_in) status_nx = ST_BADPOS;
				else              count_nx  = cnt_m1;
			end
			ACT_POP: begin
				if (!has_any) begin
					status_nx = ST_EMPTY;
				end else begin
					count_nx = cnt_m1;
					rd_en    = 1'b1;
					rd_sel   = cnt_m1;
				end
			end
			ACT_OVERWRITE: begin
				if (!pos_in) status_nx = ST_BADPOS;
			end
			ACT_READ: begin
				if (!pos_in) status_nx = ST_BADPOS;
				else         rd_en     = 1'b1;
			end
			ACT_CLEAR: count_nx = '0;
			default: ;
		endcase
	end

	assign rd_idx   = rd_sel[AW-1:0];
	assign value_nx = rd_en ? 32'(cell_word[rd_idx]) : 32'd0;

	// the cell row: each cell decides its own move from its index
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CMPW-1:0] IDX = CMPW'(i);

		if (i == 0) begin : g_first
			assign left_w[i] = cell_word[i];
		end else begin : g_left
			assign left_w[i] = cell_word[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w[i] = cell_word[i];
		end else begin : g_right
			assign right_w[i] = cell_word[i+1];
		end

		always_comb begin
			cell_op[i] = CELL_HOLD;
			if (accept) begin
				case (action)
					ACT_INSERT: begin
						if (!full) begin
							if (IDX == pos_eff)
								cell_op[i] = CELL_LOAD;
							else if (IDX > pos_eff && IDX <= count_x)
								cell_op[i] = CELL_TAKE_LEFT;
						end
					end
					ACT_ERASE: begin
						if (has_any && pos_in && IDX >= pos_x && IDX < cnt_m1)
							cell_op[i] = CELL_TAKE_RIGHT;
					end
					ACT_OVERWRITE: begin
						if (pos_in && IDX == pos_x)
							cell_op[i] = CELL_LOAD;
					end
					default: ;
				endcase
			end
		end

		pal_cell #(
			.WORD_BITS (WORD_BITS)
		) u_cell (
			.clk        (clk),
			.op         (cell_op[i]),
			.load_word  (load_w),
			.left_word  (left_w[i]),
			.right_word (right_w[i]),
			.word       (cell_word[i])
		);
	end

	// capacity after a register write, saturated to the built depth
	assign cfg_ucap = (CMPW'(cfg_data) > DEPTH_C) ? DEPTH_C : CMPW'(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= 5'd16;
		end else if (cfg_we) begin
			cap_q <= cfg_data;
			if (count_x > cfg_ucap)
				count_q <= cfg_ucap[CW-1:0];
		end else if (accept) begin
			count_q <= count_nx[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_out_q   <= value_nx;
			entry_count_q <= count_nx[4:0];
			is_empty_q    <= count_nx == '0;
			status_q      <= status_nx;
		end
	end

	assign out_valid   = out_valid_q;
	assign value_out   = value_out_q;
	assign entry_count = entry_count_q;
	assign is_empty    = is_empty_q;
	assign status      = status_q;

endmodule

@@ rtl/core/pal_checker.sv @@
module pal_checker import pal_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [2:0]  action,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] value_out,
	input logic [4:0]  entry_count,
	input logic        is_empty,
	input logic [1:0]  status
);

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value_out) && $stable(status))
		else $error("result changed while stalled");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (entry_count == 5'd0)))
		else $error("empty flag disagrees with count");

	// failed actions return no word
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY || status == ST_BADPOS) |-> value_out == 32'd0)
		else $error("word returned by a failed action");

	// a clear transfer yields an empty list next cycle
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == ACT_CLEAR |=>
			out_valid && is_empty && status == ST_OK)
		else $error("clear did not empty the list");

endmodule

bind positional_array_list_core pal_checker u_pal_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 1ps

// Testbench for positional_array_list_core.
// A sender walks a short table of hand-picked list actions, then several
// phases of random actions, each phase with its own capacity setting. Every
// accepted transfer runs through a local model of the list, and the result
// it yields (or a directed row's typed result) is queued. A checker compares
// each output transfer with the oldest queued result, field by field.
module tb import pal_pkg::*;;

	localparam int LIST_DEPTH      = 16;
	localparam int STALL_LIMIT     = 2000; // cycles without any transfer
	localparam int HOLD_OFF_CYCLES = 80;   // long receiver stall, fills the block
	localparam int DRAIN_CYCLES    = 8;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 138;
	localparam int PRESSURE_PHASE  = 1;

	// action codes the block treats as no-ops
	localparam logic [2:0] ACT_SPARE_6 = 3'd6;
	localparam logic [2:0] ACT_SPARE_7 = 3'd7;

	// one result transfer, in port order
	typedef struct packed {
		logic [31:0] word;
		logic [4:0]  count;
		logic        empty;
		status_t     code;
	} list_result_t;

	// directed row: either a capacity write or one action, with the result
	// typed in where it is obvious
	typedef struct packed {
		logic        is_cfg;
		logic [4:0]  cap;
		logic [2:0]  act;
		logic [3:0]  pos;
		logic [31:0] word;
		logic        typed;
		list_result_t result;
	} step_row_t;

	localparam int DIRECTED_ROWS = 27;
	localparam step_row_t DIRECTED [DIRECTED_ROWS] = '{
		// empty list right after reset: every access is refused
		'{1'b0, 5'd0, ACT_READ,      4'd0,  32'h0000_0000, 1'b1, '{32'h0, 5'd0, 1'b1, ST_BADPOS}},
		'{1'b0, 5'd0, ACT_POP,       4'd0,  32'h0000_0000, 1'b1, '{32'h0, 5'd0, 1'b1, ST_EMPTY}},
		'{1'b0, 5'd0, ACT_ERASE,     4'd0,  32'h0000_0000, 1'b1, '{32'h0, 5'd0, 1'b1, ST_EMPTY}},
		'{1'b0, 5'd0, ACT_OVERWRITE, 4'd0,  32'hDEAD_BEEF, 1'b1, '{32'h0, 5'd0, 1'b1, ST_BADPOS}},
		// insert far past the end is clamped to an append
		'{1'b0, 5'd0, ACT_INSERT,    4'd15, 32'hFFFF_FFFF, 1'b1, '{32'h0, 5'd1, 1'b0, ST_OK}},
		// insert at the head
		'{1'b0, 5'd0, ACT_INSERT,    4'd0,  32'h0000_0000, 1'b1, '{32'h0, 5'd2, 1'b0, ST_OK}},
		'{1'b0, 5'd0, ACT_INSERT,    4'd1,  32'hA5A5_5A5A, 1'b0, '0},
		'{1'b0, 5'd0, ACT_READ,      4'd0,  32'h0000_0000, 1'b0, '0},
		'{1'b0, 5'd0, ACT_READ,      4'd2,  32'h0000_0000, 1'b0, '0},
		'{1'b0, 5'd0, ACT_OVERWRITE, 4'd1,  32'h1234_5678, 1'b0, '0},
		'{1'b0, 5'd0, ACT_READ,      4'd1,  32'h0000_0000, 1'b0, '0},
		// position equal to the count is past the end
		'{1'b0, 5'd0, ACT_READ,      4'd3,  32'h0000_0000, 1'b1, '{32'h0, 5'd3, 1'b0, ST_BADPOS}},
		'{1'b0, 5'd0, ACT_ERASE,     4'd3,  32'h0000_0000, 1'b1, '{32'h0, 5'd3, 1'b0, ST_BADPOS}},
		'{1'b0, 5'd0, ACT_ERASE,     4'd0,  32'h0000_0000, 1'b0, '0},
		// unused codes leave the list alone
		'{1'b0, 5'd0, ACT_SPARE_6,   4'd9,  32'hFFFF_FFFF, 1'b0, '0},
		'{1'b0, 5'd0, ACT_SPARE_7,   4'd15, 32'hFFFF_FFFF, 1'b0, '0},
		'{1'b0, 5'd0, ACT_POP,       4'd0,  32'h0000_0000, 1'b0, '0},
		'{1'b0, 5'd0, ACT_CLEAR,     4'd5,  32'h0000_0000, 1'b1, '{32'h0, 5'd0, 1'b1, ST_OK}},
		// capacity one: second insert is refused as full
		'{1'b1, 5'd1, ACT_INSERT,    4'd0,  32'h0000_0000, 1'b0, '0},
		'{1'b0, 5'd0, ACT_INSERT,    4'd0,  32'h8000_0001, 1'b1, '{32'h0, 5'd1, 1'b0, ST_OK}},
		'{1'b0, 5'd0, ACT_INSERT,    4'd0,  32'h5555_AAAA, 1'b1, '{32'h0, 5'd1, 1'b0, ST_FULL}},
		'{1'b0, 5'd0, ACT_READ,      4'd0,  32'h0000_0000, 1'b0, '0},
		// capacity zero cuts the count and refuses every insert
		'{1'b1, 5'd0, ACT_INSERT,    4'd0,  32'h0000_0000, 1'b0, '0},
		'{1'b0, 5'd0, ACT_INSERT,    4'd0,  32'h0F0F_F0F0, 1'b1, '{32'h0, 5'd0, 1'b1, ST_FULL}},
		// capacity above the depth saturates
		'{1'b1, 5'd31, ACT_INSERT,   4'd0,  32'h0000_0000, 1'b0, '0},
		'{1'b0, 5'd0, ACT_INSERT,    4'd7,  32'h7FFF_FFFF, 1'b0, '0},
		'{1'b0, 5'd0, ACT_READ,      4'd0,  32'h0000_0000, 1'b0, '0}
	};

	// per phase: capacity written at its start, idle percentages per side
	localparam int PHASE_CAP       [PHASES] = '{4, 16, 1, 9, 0, 16, 2, 31, 13, 16};
	localparam int PHASE_SEND_IDLE [PHASES] = '{20, 0, 30, 10, 25, 0, 40, 15, 0, 0};
	localparam int PHASE_RECV_IDLE [PHASES] = '{20, 0, 30, 0, 25, 10, 40, 15, 0, 0};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  action;
	logic [3:0]  position;
	logic [31:0] value_in;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] value_out;
	logic [4:0]  entry_count;
	logic        is_empty;
	logic [1:0]  status;
	logic        cfg_we;
	logic [4:0]  cfg_data;

	// local copy of the list and its capacity register
	logic [31:0] list_words [LIST_DEPTH];
	int          list_len;
	logic [4:0]  cap_reg;

	list_result_t pending_results [$];
	list_result_t wanted;
	int          fail_count;
	int          results_seen;
	int          idle_cycles;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          hold_off_req;

	positional_array_list_core #(
		.DEPTH     (LIST_DEPTH),
		.WORD_BITS (32)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.position    (position),
		.value_in    (value_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.value_out   (value_out),
		.entry_count (entry_count),
		.is_empty    (is_empty),
		.status      (status),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	// register value saturated to the built depth
	function automatic int usable_cap();
		return (cap_reg > LIST_DEPTH) ? LIST_DEPTH : int'(cap_reg);
	endfunction

	// Apply one action to the local list and return the result it produces.
	function automatic list_result_t list_apply(input logic [2:0] act, input logic [3:0] pos,
			input logic [31:0] word);
		list_result_t res;
		int slot;
		int i;
		res = '0;
		res.code = ST_OK;
		slot = pos;
		case (act)
			ACT_INSERT: begin
				if (list_len >= usable_cap()) begin
					res.code = ST_FULL;
				end else begin
					if (slot > list_len)
						slot = list_len;
					for (i = list_len; i > slot; i--)
						list_words[i] = list_words[i - 1];
					list_words[slot] = word;
					list_len++;
				end
			end
			ACT_ERASE: begin
				if (list_len == 0) begin
					res.code = ST_EMPTY;
				end else if (slot >= list_len) begin
					res.code = ST_BADPOS;
				end else begin
					for (i = slot; i + 1 < list_len; i++)
						list_words[i] = list_words[i + 1];
					list_len--;
				end
			end
			ACT_POP: begin
				if (list_len == 0) begin
					res.code = ST_EMPTY;
				end else begin
					list_len--;
					res.word = list_words[list_len];
				end
			end
			ACT_OVERWRITE: begin
				if (slot >= list_len)
					res.code = ST_BADPOS;
				else
					list_words[slot] = word;
			end
			ACT_READ: begin
				if (slot >= list_len)
					res.code = ST_BADPOS;
				else
					res.word = list_words[slot];
			end
			ACT_CLEAR: begin
				list_len = 0;
			end
			default: begin
			end
		endcase
		res.count = 5'(list_len);
		res.empty = (list_len == 0);
		return res;
	endfunction

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endfunction

	// Offer one action, wait for its transfer, then queue its result. Entered
	// and left at a falling edge, so valid is touched once per time step.
	task automatic send_item(input logic [2:0] act, input logic [3:0] pos,
			input logic [31:0] word, input logic typed, input list_result_t typed_result);
		list_result_t predicted;
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		position <= pos;
		value_in <= word;
		do @(posedge clk); while (!in_ready);
		predicted = list_apply(act, pos, word);
		pending_results.push_back(typed ? typed_result : predicted);
		@(negedge clk);
	endtask

	// Capacity writes only happen with the block drained.
	task automatic write_capacity(input logic [4:0] cap);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= cap;
		@(negedge clk);
		cfg_we <= 1'b0;
		cap_reg = cap;
		// lowering the capacity drops the entries above it
		if (list_len > usable_cap())
			list_len = usable_cap();
	endtask

	// Random action, biased toward positions that hit live entries and toward
	// inserts so that the list fills up and the full case comes often.
	task automatic pick_item(output logic [2:0] act, output logic [3:0] pos,
			output logic [31:0] word);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			act = ACT_INSERT;
		else if (roll < 50)
			act = ACT_ERASE;
		else if (roll < 58)
			act = ACT_POP;
		else if (roll < 70)
			act = ACT_OVERWRITE;
		else if (roll < 97)
			act = ACT_READ;
		else if (roll < 98)
			act = ACT_CLEAR;
		else if (roll < 99)
			act = ACT_SPARE_6;
		else
			act = ACT_SPARE_7;
		if (list_len > 0 && $urandom_range(0, 9) < 8)
			pos = 4'($urandom_range(0, list_len - 1));
		else
			pos = 4'($urandom_range(0, 15));
		case ($urandom_range(0, 9))
			0: word = '0;
			1: word = '1;
			default: word = $urandom;
		endcase
	endtask

	// Receiver: random stall bursts, plus one long hold-off on request while
	// the sender keeps offering, so the block backs up and drops in_ready.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				out_ready <= 1'b1;
			end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Result checker: each output transfer against the oldest queued result.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				note_failure($sformatf("result %0d with nothing pending: word=%h count=%0d",
					results_seen, value_out, entry_count));
			end else begin
				wanted = pending_results.pop_front();
				if (value_out !== wanted.word || entry_count !== wanted.count ||
						is_empty !== wanted.empty || status !== wanted.code)
					note_failure($sformatf({"result %0d: expected word=%h count=%0d ",
						"empty=%0b status=%0d, got word=%h count=%0d empty=%0b status=%0d"},
						results_seen, wanted.word, wanted.count, wanted.empty, wanted.code,
						value_out, entry_count, is_empty, status));
			end
		end
	end

	// Watchdog: ends the run when no transfer happens for too long.
	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAIL positional_array_list_core");
		$finish;
	end

	initial begin
		int ph;
		int n;
		logic [2:0]  act;
		logic [3:0]  pos;
		logic [31:0] word;

		// every input known from time zero, reset held from the start and released at a falling edge
		arst_n   = 1'b0;
		in_valid = 1'b0;
		action   = ACT_INSERT;
		position = '0;
		value_in = '0;
		cfg_we   = 1'b0;
		cfg_data = '0;
		list_len = 0;
		cap_reg  = 5'd16;
		fail_count    = 0;
		results_seen  = 0;
		hold_off_req  = 1'b0;
		send_idle_pct = 15;
		recv_idle_pct = 15;
		foreach (list_words[i])
			list_words[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		foreach (DIRECTED[r]) begin
			if (DIRECTED[r].is_cfg)
				write_capacity(DIRECTED[r].cap);
			else
				send_item(DIRECTED[r].act, DIRECTED[r].pos, DIRECTED[r].word,
					DIRECTED[r].typed, DIRECTED[r].result);
		end

		// random phases; the last two run with no idling on either side
		for (ph = 0; ph < PHASES; ph++) begin
			write_capacity(5'(PHASE_CAP[ph]));
			send_idle_pct = PHASE_SEND_IDLE[ph];
			recv_idle_pct = PHASE_RECV_IDLE[ph];
			if (ph == PRESSURE_PHASE)
				hold_off_req = 1'b1;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick_item(act, pos, word);
				send_item(act, pos, word, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("PASS positional_array_list_core");
		else
			$display("FAIL positional_array_list_core");
		$finish;
	end

endmodule
